// ===== hdl/bhsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsv_pkg
// Shared types and constants of the pixel color space converter.
// ----------------------------------------------------------------------------
package bhsv_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned NUM_W   = 16;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QAW     = 2;
  localparam int unsigned QCW     = 3;
  localparam int unsigned QBITS   = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              last_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] value;
    logic              last_out;
  } pix_out_t;

  typedef struct packed {
    logic [NUM_W-1:0]  hue_num;
    logic [CHAN_W-1:0] hue_den;
    logic [NUM_W-1:0]  sat_num;
    logic [CHAN_W-1:0] value;
    logic              flat;
    logic              last;
  } job_t;

endpackage

// ===== hdl/bhsv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsv_front
// Accepts a pixel, finds maximum, minimum and sector, and forms the
// numerators and denominators of the two divisions.
// ----------------------------------------------------------------------------
module bhsv_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  bhsv_pkg::pix_in_t in_pixel,
  output logic            job_valid,
  input  logic            job_ready,
  output bhsv_pkg::job_t  job
);
  import bhsv_pkg::*;

  logic              valid_r, valid_nxt;
  job_t              job_r, job_nxt;
  logic              accept;
  logic [CHAN_W-1:0] b, g, r, vmax, vmin, d;
  logic [NUM_W-1:0]  d16, b16, g16, r16;

  assign accept  = in_push && !in_full;
  assign in_full = valid_r && !job_ready;

  always_comb begin
    b = in_pixel.blue;
    g = in_pixel.green;
    r = in_pixel.red;
    vmax = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    vmin = r;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    d   = vmax - vmin;
    d16 = {8'd0, d};
    b16 = {8'd0, b};
    g16 = {8'd0, g};
    r16 = {8'd0, r};
    job_nxt.hue_den = d;
    job_nxt.sat_num = (d16 << 8) - d16;
    job_nxt.value   = vmax;
    job_nxt.flat    = (d == 8'd0);
    job_nxt.last    = in_pixel.last_in;
    priority if (r >= g && r >= b) begin
      if (g >= b) job_nxt.hue_num = 16'd30 * (g16 - b16);
      else job_nxt.hue_num = 16'd180 * d16 - 16'd30 * (b16 - g16);
    end else if (g >= b) begin
      job_nxt.hue_num = 16'd60 * d16 + 16'd30 * b16 - 16'd30 * r16;
    end else begin
      job_nxt.hue_num = 16'd120 * d16 + 16'd30 * r16 - 16'd30 * g16;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) valid_nxt = 1'b1;
    else if (job_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = valid_r;
  assign job       = job_r;

endmodule

// ===== hdl/bhsv_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsv_queue
// Short first-in first-out queue of division jobs between front and back.
// ----------------------------------------------------------------------------
module bhsv_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  bhsv_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_take,
  output bhsv_pkg::job_t rd_job
);
  import bhsv_pkg::*;

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign wr_ready = (cnt_r != QCW'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;
  assign rd_job   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

endmodule

// ===== hdl/bhsv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsv_back
// Two pipelined restoring dividers, one quotient bit per stage, that give
// hue and saturation; the last stage holds the result word.
// ----------------------------------------------------------------------------
module bhsv_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_take,
  input  bhsv_pkg::job_t     job,
  output logic               out_empty,
  input  logic               out_pop,
  output bhsv_pkg::pix_out_t out_pixel
);
  import bhsv_pkg::*;

  logic              vld_r  [QBITS+1];
  logic [NUM_W-1:0]  hrem_r [QBITS+1];
  logic [NUM_W-1:0]  srem_r [QBITS+1];
  logic [CHAN_W-1:0] hden_r [QBITS+1];
  logic [CHAN_W-1:0] sden_r [QBITS+1];
  logic [CHAN_W-1:0] hq_r   [QBITS+1];
  logic [CHAN_W-1:0] sq_r   [QBITS+1];
  logic              flat_r [QBITS+1];
  logic              last_r [QBITS+1];
  logic              adv;

  assign adv      = !vld_r[QBITS] || out_pop;
  assign job_take = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hrem_r[0] <= job.hue_num;
      srem_r[0] <= job.sat_num;
      hden_r[0] <= job.hue_den;
      sden_r[0] <= job.value;
      hq_r[0]   <= '0;
      sq_r[0]   <= '0;
      flat_r[0] <= job.flat;
      last_r[0] <= job.last;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic [NUM_W-1:0] hsh, ssh;
    logic             hge, sge;

    assign hsh = {8'd0, hden_r[k]} << (QBITS - 1 - k);
    assign ssh = {8'd0, sden_r[k]} << (QBITS - 1 - k);
    assign hge = (hrem_r[k] >= hsh);
    assign sge = (srem_r[k] >= ssh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hrem_r[k+1] <= hge ? hrem_r[k] - hsh : hrem_r[k];
        srem_r[k+1] <= sge ? srem_r[k] - ssh : srem_r[k];
        hden_r[k+1] <= hden_r[k];
        sden_r[k+1] <= sden_r[k];
        hq_r[k+1]   <= {hq_r[k][CHAN_W-2:0], hge};
        sq_r[k+1]   <= {sq_r[k][CHAN_W-2:0], sge};
        flat_r[k+1] <= flat_r[k];
        last_r[k+1] <= last_r[k];
      end
    end
  end

  // A grey or black pixel has a zero divisor; both quotients are zero then.
  always_comb begin
    out_pixel.hue        = flat_r[QBITS] ? '0 : hq_r[QBITS];
    out_pixel.saturation = flat_r[QBITS] ? '0 : sq_r[QBITS];
    out_pixel.value      = sden_r[QBITS];
    out_pixel.last_out   = last_r[QBITS];
  end

  assign out_empty = !vld_r[QBITS];

endmodule

// ===== hdl/bgr_to_hsv_pixel_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_to_hsv_pixel_core
// Converts 8-bit blue, green and red pixels to hue (0 to 179), saturation
// and value.
// ----------------------------------------------------------------------------
// The core takes one pixel word per clock and returns one result word per
// clock as long as results are popped. A pixel passes the front stage, the
// four-entry job queue and the nine registered stages of the back end,
// whose two dividers each retire one quotient bit per stage. When the result
// is not popped the back end holds, the queue fills, and full rises once the
// queue and the front stage are both occupied.
module bgr_to_hsv_pixel_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  bhsv_pkg::pix_in_t  in_pixel,
  output logic               out_empty,
  input  logic               out_pop,
  output bhsv_pkg::pix_out_t out_pixel
);
  import bhsv_pkg::*;

  logic fq_valid, fq_ready, qb_valid, qb_take;
  job_t fq_job, qb_job;

  bhsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_pixel  (in_pixel),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  bhsv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_job   (fq_job),
    .rd_valid (qb_valid),
    .rd_take  (qb_take),
    .rd_job   (qb_job)
  );

  bhsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_take  (qb_take),
    .job       (qb_job),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_pixel (out_pixel)
  );

endmodule

// ===== hdl/bhsv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsv_checker
// Port-level checks of the pixel converter, bound to the top level.
// ----------------------------------------------------------------------------
module bhsv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input bhsv_pkg::pix_out_t out_pixel
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("Reset did not clear the core.");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_pixel.hue <= 8'd179)
    else $error("Hue word out of range.");

  a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pixel.value == 8'd0 |->
      out_pixel.hue == 8'd0 && out_pixel.saturation == 8'd0)
    else $error("Black pixel gave nonzero hue or saturation.");

  a_sat_grey: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pixel.saturation == 8'd0 && out_pixel.value != 8'd0 |->
      out_pixel.hue == 8'd0)
    else $error("Grey pixel gave nonzero hue.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_pixel))
    else $error("Result word changed while waiting.");

endmodule

bind bgr_to_hsv_pixel_core bhsv_checker u_bhsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_pixel (out_pixel)
);

// ===== tb/bgr_to_hsv_pixel_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_to_hsv_pixel_core_tb
// Pushes a short table of directed pixels and then 1150 random pixels into
// the converter. Both sides stall at random, but not while random pixels
// 400 to 599 are pushed. Every popped word is compared field by field with
// the value predicted for the oldest pixel still waiting for its result.
// ----------------------------------------------------------------------------
module bgr_to_hsv_pixel_core_tb;
  import bhsv_pkg::*;

  localparam int unsigned NUM_RANDOM = 1150;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct {
    bit       known;
    pix_in_t  pixel;
    pix_out_t want;
  } dir_row_t;

  localparam int unsigned NUM_DIR = 23;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}, '{8'd0,   8'd0,   8'd0,   1'b0}},
    '{1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}, '{8'd0,   8'd0,   8'd255, 1'b1}},
    '{1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}, '{8'd0,   8'd255, 8'd255, 1'b0}},
    '{1'b1, '{8'd0,   8'd255, 8'd0,   1'b1}, '{8'd60,  8'd255, 8'd255, 1'b1}},
    '{1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}, '{8'd120, 8'd255, 8'd255, 1'b0}},
    '{1'b1, '{8'd0,   8'd255, 8'd255, 1'b0}, '{8'd30,  8'd255, 8'd255, 1'b0}},
    '{1'b1, '{8'd255, 8'd255, 8'd0,   1'b1}, '{8'd90,  8'd255, 8'd255, 1'b1}},
    '{1'b1, '{8'd255, 8'd0,   8'd255, 1'b0}, '{8'd150, 8'd255, 8'd255, 1'b0}},
    '{1'b1, '{8'd0,   8'd0,   8'd1,   1'b1}, '{8'd0,   8'd255, 8'd1,   1'b1}},
    '{1'b1, '{8'd1,   8'd1,   8'd1,   1'b0}, '{8'd0,   8'd0,   8'd1,   1'b0}},
    '{1'b1, '{8'd128, 8'd128, 8'd128, 1'b1}, '{8'd0,   8'd0,   8'd128, 1'b1}},
    '{1'b0, '{8'd11,  8'd10,  8'd200, 1'b0}, '0},
    '{1'b0, '{8'd50,  8'd200, 8'd200, 1'b1}, '0},
    '{1'b0, '{8'd200, 8'd200, 8'd50,  1'b0}, '0},
    '{1'b0, '{8'd200, 8'd50,  8'd200, 1'b1}, '0},
    '{1'b0, '{8'd170, 8'd85,  8'd255, 1'b0}, '0},
    '{1'b0, '{8'd1,   8'd0,   8'd255, 1'b0}, '0},
    '{1'b0, '{8'd254, 8'd255, 8'd0,   1'b1}, '0},
    '{1'b0, '{8'd0,   8'd254, 8'd255, 1'b0}, '0},
    '{1'b0, '{8'd85,  8'd170, 8'd255, 1'b1}, '0},
    '{1'b0, '{8'd255, 8'd254, 8'd253, 1'b0}, '0},
    '{1'b0, '{8'hAA,  8'h55,  8'h33,  1'b1}, '0},
    '{1'b0, '{8'h55,  8'hAA,  8'hCC,  1'b0}, '0}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  pix_in_t  in_pixel = '0;
  logic     out_empty;
  logic     out_pop = 1'b0;
  pix_out_t out_pixel;

  pix_out_t    hsv_due [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          no_gaps = 1'b0;

  bgr_to_hsv_pixel_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_pixel  (in_pixel),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_pixel (out_pixel)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic pix_out_t hsv_of(pix_in_t p);
    int b;
    int g;
    int r;
    int v;
    int lo;
    int d;
    int num;
    int h;
    pix_out_t o;
    b = p.blue;
    g = p.green;
    r = p.red;
    v = (r > g) ? r : g;
    v = (b > v) ? b : v;
    lo = (r < g) ? r : g;
    lo = (b < lo) ? b : lo;
    d = v - lo;
    h = 0;
    if (d > 0) begin
      if (v == r) begin
        num = 30 * (g - b);
        if (num < 0) begin
          num += 180 * d;
        end
      end else if (v == g) begin
        num = 60 * d + 30 * (b - r);
      end else begin
        num = 120 * d + 30 * (r - g);
      end
      h = num / d;
      if (h > 179) begin
        h = 179;
      end
    end
    o.hue = h[7:0];
    o.saturation = (v > 0) ? 8'((255 * d) / v) : 8'd0;
    o.value = v[7:0];
    o.last_out = p.last_in;
    return o;
  endfunction

  function automatic logic [7:0] edge_chan();
    case ($urandom_range(0, 3))
      0: edge_chan = 8'd0;
      1: edge_chan = 8'd1;
      2: edge_chan = 8'd254;
      default: edge_chan = 8'd255;
    endcase
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t p;
    logic [7:0] same;
    p.blue = 8'($urandom);
    p.green = 8'($urandom);
    p.red = 8'($urandom);
    p.last_in = ($urandom_range(0, 15) == 0);
    same = 8'($urandom);
    case ($urandom_range(0, 9))
      6: begin
        case ($urandom_range(0, 2))
          0: begin p.red = same; p.green = same; end
          1: begin p.green = same; p.blue = same; end
          default: begin p.red = same; p.blue = same; end
        endcase
      end
      7: begin
        p.blue = same;
        p.green = same;
        p.red = same;
      end
      8: begin
        p.blue = 8'($urandom_range(0, 3));
        p.green = 8'($urandom_range(0, 3));
        p.red = 8'($urandom_range(0, 3));
      end
      9: begin
        p.blue = edge_chan();
        p.green = edge_chan();
        p.red = edge_chan();
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic push_pixel(input pix_in_t p, input bit known, input pix_out_t want);
    while (!no_gaps && $urandom_range(0, 99) < 10) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    hsv_due.push_back(known ? want : hsv_of(p));
  endtask

  always @(posedge clk) begin
    pix_out_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (hsv_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected word: hue %0d sat %0d value %0d last %0b",
                     out_pixel.hue, out_pixel.saturation, out_pixel.value,
                     out_pixel.last_out);
          end
        end else begin
          want = hsv_due.pop_front();
          if (out_pixel.hue !== want.hue || out_pixel.saturation !== want.saturation ||
              out_pixel.value !== want.value || out_pixel.last_out !== want.last_out) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch: expected h %0d s %0d v %0d l %0b, got h %0d s %0d v %0d l %0b",
                       want.hue, want.saturation, want.value, want.last_out,
                       out_pixel.hue, out_pixel.saturation, out_pixel.value,
                       out_pixel.last_out);
            end
          end
        end
      end
      out_pop <= no_gaps || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("bgr_to_hsv_pixel_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      push_pixel(dir_rows[i].pixel, dir_rows[i].known, dir_rows[i].want);
    end

    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      no_gaps = (n >= 400 && n < 600);
      if (n == 700) begin
        in_push <= 1'b0;
        while (hsv_due.size() != 0) begin
          @(posedge clk);
        end
      end
      push_pixel(random_pixel(), 1'b0, '0);
    end
    in_push <= 1'b0;
    no_gaps = 1'b0;

    while (hsv_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && hsv_due.size() == 0) begin
      $display("bgr_to_hsv_pixel_core test passed");
    end else begin
      $display("bgr_to_hsv_pixel_core test failed");
    end
    $finish;
  end

endmodule
